@@ sv/nntt_pkg.sv @@
`default_nettype none

package nntt_pkg;

  // table geometry
  localparam int MaxNodes  = 1024;
  localparam int IdxW      = $clog2(MaxNodes);
  localparam int CntW      = IdxW + 1;

  // field widths
  localparam int CoordW    = 16;
  localparam int CostW     = 32;
  localparam int SqW       = 2 * CoordW;
  localparam int D2W       = SqW + 1;
  localparam int SqrtW     = CoordW + 1;
  localparam int SqAccW    = D2W + 1;
  localparam int SqrtCntW  = $clog2(SqrtW);

  // configuration port
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegStartX    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStartY    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegGoalX     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegGoalY     = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegThreshold = CfgIdxW'(4);

  localparam logic [CoordW-1:0] StartXRst    = CoordW'(256);
  localparam logic [CoordW-1:0] StartYRst    = CoordW'(256);
  localparam logic [CoordW-1:0] GoalXRst     = CoordW'(2048);
  localparam logic [CoordW-1:0] GoalYRst     = CoordW'(2048);
  localparam logic [CoordW-1:0] ThresholdRst = CoordW'(256);

  typedef enum logic [1:0] {
    CmdResetTree = 2'd0,
    CmdNearest   = 2'd1,
    CmdAdd       = 2'd2,
    CmdUnused    = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusFull      = 2'd1,
    StatusBadParent = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StSqrt,
    StFinish
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CostW-1:0]  cost;
  } node_t;

endpackage

`default_nettype wire

@@ sv/nearest_node_tree_table_unit.sv @@
`default_nettype none

// Brute-force nearest-node table for a sampling-based path planner. Node
// positions (unsigned Q8.8) and path costs (Q24.8) sit in one single-port
// synchronous memory of nntt_pkg::MaxNodes entries; the root node is held in
// registers and stands in for entry 0. A nearest request reads every stored
// node, one per cycle through the memory read port, keeps the first node with
// the smallest squared distance and takes its integer square root in a
// one-bit-per-cycle root unit (17 steps). An add request reads its parent,
// works out the distance and the goal test the same way and writes the new
// node back. reset_tree, an unused command and a refused add skip the scan
// and answer from StFinish. One request is worked on at a time; the next may
// be accepted while the last result still waits in the output register.
// Start coordinates take effect at the next reset_tree; no clearing pass is
// needed after reset.
module nearest_node_tree_table_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,

  input  wire                               cfg_we_i,
  input  wire  [nntt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [nntt_pkg::CfgDataW-1:0]     cfg_wdata_i,

  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [1:0]                        command_i,
  input  wire  [nntt_pkg::CoordW-1:0]       point_x_i,
  input  wire  [nntt_pkg::CoordW-1:0]       point_y_i,
  input  wire  [nntt_pkg::IdxW-1:0]         parent_index_i,

  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [1:0]                        status_o,
  output logic [nntt_pkg::IdxW-1:0]         node_index_o,
  output logic [nntt_pkg::CoordW-1:0]       distance_o,
  output logic [nntt_pkg::CostW-1:0]        cost_o,
  output logic                              reached_o
);

  // configuration registers
  logic [nntt_pkg::CoordW-1:0] start_x_q, start_y_q, goal_x_q, goal_y_q, thresh_q;

  // root node and fill count
  logic [nntt_pkg::CoordW-1:0] root_x_q, root_y_q;
  logic [nntt_pkg::CntW-1:0]   count_q;

  // latched request
  nntt_pkg::command_e          cmd_q;
  nntt_pkg::status_e           status_q;
  logic [nntt_pkg::CoordW-1:0] px_q, py_q;

  // control
  nntt_pkg::state_e            state_q, state_d;
  logic [nntt_pkg::IdxW-1:0]   scan_idx_q, scan_end_q;
  logic                        scan_first_q;

  logic accept, scan_issue, sqrt_init, out_load;
  nntt_pkg::command_e in_cmd;

  // node memory
  nntt_pkg::node_t node_mem_q [nntt_pkg::MaxNodes];
  nntt_pkg::node_t rd_data_q;
  nntt_pkg::node_t wr_data;
  logic            mem_we;

  // distance pipeline
  logic                        p1_vld_q, p1_first_q, p1_root_q;
  logic [nntt_pkg::IdxW-1:0]   p1_idx_q;
  nntt_pkg::node_t             p1_node;

  logic                        s2_vld_q, s2_first_q;
  logic [nntt_pkg::IdxW-1:0]   s2_idx_q;
  logic [nntt_pkg::CostW-1:0]  s2_cost_q;
  logic [nntt_pkg::CoordW-1:0] s2_dx_q, s2_dy_q, s2_gdx_q, s2_gdy_q;

  logic                        s3_vld_q, s3_first_q;
  logic [nntt_pkg::IdxW-1:0]   s3_idx_q;
  logic [nntt_pkg::CostW-1:0]  s3_cost_q;
  logic [nntt_pkg::SqW-1:0]    s3_sqx_q, s3_sqy_q, s3_gsx_q, s3_gsy_q, s3_tsq_q;
  logic [nntt_pkg::D2W-1:0]    s3_d2, s3_g2;

  // best node so far
  logic [nntt_pkg::D2W-1:0]    best_d2_q;
  logic [nntt_pkg::IdxW-1:0]   best_idx_q;
  logic [nntt_pkg::CostW-1:0]  best_cost_q;
  logic                        reached_q;

  // square root unit
  logic [nntt_pkg::SqAccW-1:0]   sq_rem_q, sq_res_q, sq_bit_q, sq_trial;
  logic [nntt_pkg::SqrtCntW-1:0] sq_cnt_q;

  // result assembly
  logic [nntt_pkg::SqrtW-1:0]  root_val;
  logic [nntt_pkg::CoordW-1:0] dist_sat;
  logic [nntt_pkg::CostW:0]    cost_sum;
  logic [nntt_pkg::CostW-1:0]  cost_sat;

  assign in_cmd = nntt_pkg::command_e'(command_i);
  assign accept = in_valid_i & in_ready_o;

  // configuration writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= nntt_pkg::StartXRst;
      start_y_q <= nntt_pkg::StartYRst;
      goal_x_q  <= nntt_pkg::GoalXRst;
      goal_y_q  <= nntt_pkg::GoalYRst;
      thresh_q  <= nntt_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nntt_pkg::RegStartX:    start_x_q <= cfg_wdata_i;
        nntt_pkg::RegStartY:    start_y_q <= cfg_wdata_i;
        nntt_pkg::RegGoalX:     goal_x_q  <= cfg_wdata_i;
        nntt_pkg::RegGoalY:     goal_y_q  <= cfg_wdata_i;
        nntt_pkg::RegThreshold: thresh_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nntt_pkg::StIdle: begin
        if (accept) begin
          if (in_cmd == nntt_pkg::CmdNearest) begin
            state_d = nntt_pkg::StScan;
          end else if (in_cmd == nntt_pkg::CmdAdd &&
                       count_q < nntt_pkg::CntW'(nntt_pkg::MaxNodes) &&
                       {1'b0, parent_index_i} < count_q) begin
            state_d = nntt_pkg::StScan;
          end else begin
            state_d = nntt_pkg::StFinish;
          end
        end
      end
      nntt_pkg::StScan: begin
        if (scan_idx_q == scan_end_q) state_d = nntt_pkg::StDrain;
      end
      nntt_pkg::StDrain: begin
        if (!p1_vld_q && !s2_vld_q && !s3_vld_q) state_d = nntt_pkg::StSqrt;
      end
      nntt_pkg::StSqrt: begin
        if (sq_cnt_q == nntt_pkg::SqrtCntW'(nntt_pkg::SqrtW - 1)) state_d = nntt_pkg::StFinish;
      end
      nntt_pkg::StFinish: begin
        if (!out_valid_o || out_ready_i) state_d = nntt_pkg::StIdle;
      end
      default: state_d = nntt_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    scan_issue = 1'b0;
    sqrt_init  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      nntt_pkg::StIdle:   in_ready_o = 1'b1;
      nntt_pkg::StScan:   scan_issue = 1'b1;
      nntt_pkg::StDrain:  sqrt_init  = !p1_vld_q && !s2_vld_q && !s3_vld_q;
      nntt_pkg::StSqrt:   ;
      nntt_pkg::StFinish: out_load   = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nntt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture, root and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_x_q <= nntt_pkg::StartXRst;
      root_y_q <= nntt_pkg::StartYRst;
      count_q  <= nntt_pkg::CntW'(1);
      cmd_q    <= nntt_pkg::CmdUnused;
      status_q <= nntt_pkg::StatusOk;
    end else begin
      if (accept) begin
        cmd_q    <= in_cmd;
        status_q <= nntt_pkg::StatusOk;
        if (in_cmd == nntt_pkg::CmdResetTree) begin
          root_x_q <= start_x_q;
          root_y_q <= start_y_q;
          count_q  <= nntt_pkg::CntW'(1);
        end else if (in_cmd == nntt_pkg::CmdAdd) begin
          // full table is checked before the parent
          if (count_q >= nntt_pkg::CntW'(nntt_pkg::MaxNodes)) begin
            status_q <= nntt_pkg::StatusFull;
          end else if ({1'b0, parent_index_i} >= count_q) begin
            status_q <= nntt_pkg::StatusBadParent;
          end
        end
      end
      if (mem_we) count_q <= count_q + nntt_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  // scan sequencer: nearest sweeps all nodes, add reads only the parent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      scan_end_q   <= '0;
      scan_first_q <= 1'b0;
    end else if (accept) begin
      scan_first_q <= 1'b1;
      if (in_cmd == nntt_pkg::CmdNearest) begin
        scan_idx_q <= '0;
        scan_end_q <= nntt_pkg::IdxW'(count_q - nntt_pkg::CntW'(1));
      end else begin
        scan_idx_q <= parent_index_i;
        scan_end_q <= parent_index_i;
      end
    end else if (scan_issue) begin
      scan_first_q <= 1'b0;
      scan_idx_q   <= scan_idx_q + nntt_pkg::IdxW'(1);
    end
  end

  // node memory, one write or one read a cycle
  assign mem_we       = out_load && cmd_q == nntt_pkg::CmdAdd && status_q == nntt_pkg::StatusOk;
  assign wr_data.x    = px_q;
  assign wr_data.y    = py_q;
  assign wr_data.cost = cost_sat;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[count_q[nntt_pkg::IdxW-1:0]] <= wr_data;
    end else if (scan_issue) begin
      rd_data_q <= node_mem_q[scan_idx_q];
    end
  end

  // stage 1: read data back, root stands in for entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= scan_first_q;
    p1_root_q  <= scan_idx_q == '0;
    p1_idx_q   <= scan_idx_q;
  end

  always_comb begin
    if (p1_root_q) begin
      p1_node.x    = root_x_q;
      p1_node.y    = root_y_q;
      p1_node.cost = '0;
    end else begin
      p1_node = rd_data_q;
    end
  end

  // stage 2: absolute differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_first_q <= p1_first_q;
    s2_idx_q   <= p1_idx_q;
    s2_cost_q  <= p1_node.cost;
    s2_dx_q    <= (px_q > p1_node.x) ? px_q - p1_node.x : p1_node.x - px_q;
    s2_dy_q    <= (py_q > p1_node.y) ? py_q - p1_node.y : p1_node.y - py_q;
    s2_gdx_q   <= (px_q > goal_x_q) ? px_q - goal_x_q : goal_x_q - px_q;
    s2_gdy_q   <= (py_q > goal_y_q) ? py_q - goal_y_q : goal_y_q - py_q;
  end

  // stage 3: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_first_q <= s2_first_q;
    s3_idx_q   <= s2_idx_q;
    s3_cost_q  <= s2_cost_q;
    s3_sqx_q   <= s2_dx_q * s2_dx_q;
    s3_sqy_q   <= s2_dy_q * s2_dy_q;
    s3_gsx_q   <= s2_gdx_q * s2_gdx_q;
    s3_gsy_q   <= s2_gdy_q * s2_gdy_q;
    s3_tsq_q   <= thresh_q * thresh_q;
  end

  assign s3_d2 = {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};
  assign s3_g2 = {1'b0, s3_gsx_q} + {1'b0, s3_gsy_q};

  // stage 4: keep the first smallest distance, strict compare keeps lowest index
  always_ff @(posedge clk_i) begin
    if (s3_vld_q && (s3_first_q || s3_d2 < best_d2_q)) begin
      best_d2_q   <= s3_d2;
      best_idx_q  <= s3_idx_q;
      best_cost_q <= s3_cost_q;
    end
    if (s3_vld_q) reached_q <= s3_g2 < {1'b0, s3_tsq_q};
  end

  // integer square root, one result bit per cycle
  assign sq_trial = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (sqrt_init) begin
      sq_cnt_q <= '0;
    end else if (state_q == nntt_pkg::StSqrt) begin
      sq_cnt_q <= sq_cnt_q + nntt_pkg::SqrtCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_init) begin
      sq_rem_q <= {1'b0, best_d2_q};
      sq_res_q <= '0;
      sq_bit_q <= nntt_pkg::SqAccW'(1) << (2 * (nntt_pkg::SqrtW - 1));
    end else if (state_q == nntt_pkg::StSqrt) begin
      if (sq_rem_q >= sq_trial) begin
        sq_rem_q <= sq_rem_q - sq_trial;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // result: distance field saturates, cost sum uses the full root
  assign root_val = sq_res_q[nntt_pkg::SqrtW-1:0];
  assign dist_sat = root_val[nntt_pkg::SqrtW-1] ? '1 : root_val[nntt_pkg::CoordW-1:0];
  assign cost_sum = {1'b0, best_cost_q} +
                    (nntt_pkg::CostW + 1)'(root_val);
  assign cost_sat = cost_sum[nntt_pkg::CostW] ? '1 : cost_sum[nntt_pkg::CostW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o     <= status_q;
      node_index_o <= '0;
      distance_o   <= '0;
      cost_o       <= '0;
      reached_o    <= 1'b0;
      if (cmd_q == nntt_pkg::CmdNearest) begin
        node_index_o <= best_idx_q;
        distance_o   <= dist_sat;
        cost_o       <= best_cost_q;
      end else if (mem_we) begin
        node_index_o <= count_q[nntt_pkg::IdxW-1:0];
        distance_o   <= dist_sat;
        cost_o       <= cost_sat;
        reached_o    <= reached_q;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_nearest_node_tree_table_unit.sv @@
`timescale 1ns / 1ps

module tb_nearest_node_tree_table_unit;

  // overall run limit in clock cycles, far beyond the slowest correct run
  localparam int CycleLimit = 4_000_000;
  // requests per register setting in the random part
  localparam int PhaseRequests = 65;
  localparam int PhaseCount = 8;
  // cycles the sink holds off once, so that the unit backs up into its input
  localparam int LongHold = 400;
  // quiet cycles after the last answer
  localparam int TailCycles = 64;

  // one request as offered on the input channel
  typedef struct packed {
    nntt_pkg::command_e          cmd;
    logic [nntt_pkg::CoordW-1:0] px;
    logic [nntt_pkg::CoordW-1:0] py;
    logic [nntt_pkg::IdxW-1:0]   parent;
  } request_t;

  // one answer as seen on the output channel
  typedef struct packed {
    nntt_pkg::status_e           status;
    logic [nntt_pkg::IdxW-1:0]   node;
    logic [nntt_pkg::CoordW-1:0] distance;
    logic [nntt_pkg::CostW-1:0]  cost;
    logic                        reached;
  } answer_t;

  // directed row: the answer is typed in where by_hand is set
  typedef struct packed {
    request_t rq;
    logic     by_hand;
    answer_t  want;
  } row_t;

  // default registers: root (256, 256), goal (2048, 2048), threshold 256
  localparam row_t DirectedRows [22] = '{
    // query straight after reset finds the root
    '{'{nntt_pkg::CmdNearest, 16'd256, 16'd256, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd0, 16'd0, 32'd0, 1'b0}},
    // tree clear answers all zero whatever the payload
    '{'{nntt_pkg::CmdResetTree, 16'hFFFF, 16'hFFFF, 10'h3FF}, 1'b1, '0},
    // unused command changes nothing
    '{'{nntt_pkg::CmdUnused, 16'hFFFF, 16'h0000, 10'h3FF}, 1'b1, '0},
    // parent not yet stored, equal to the count and at the top
    '{'{nntt_pkg::CmdAdd, 16'd0, 16'd0, 10'd1}, 1'b1,
      '{nntt_pkg::StatusBadParent, 10'd0, 16'd0, 32'd0, 1'b0}},
    '{'{nntt_pkg::CmdAdd, 16'hFFFF, 16'hFFFF, 10'h3FF}, 1'b1,
      '{nntt_pkg::StatusBadParent, 10'd0, 16'd0, 32'd0, 1'b0}},
    // corner under the root: sqrt(2 * 256^2) = 362
    '{'{nntt_pkg::CmdAdd, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd1, 16'd362, 32'd362, 1'b0}},
    // far corner: the distance field saturates, the cost takes the full root
    '{'{nntt_pkg::CmdAdd, 16'hFFFF, 16'hFFFF, 10'd1}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd2, 16'hFFFF, 32'd93042, 1'b0}},
    // on the goal, on the threshold circle, just inside it
    '{'{nntt_pkg::CmdAdd, 16'd2048, 16'd2048, 10'd0}, 1'b0, '0},
    '{'{nntt_pkg::CmdAdd, 16'd2304, 16'd2048, 10'd3}, 1'b0, '0},
    '{'{nntt_pkg::CmdAdd, 16'd2303, 16'd2048, 10'd4}, 1'b0, '0},
    // exact hits on stored corners
    '{'{nntt_pkg::CmdNearest, 16'hFFFF, 16'hFFFF, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd2, 16'd0, 32'd93042, 1'b0}},
    '{'{nntt_pkg::CmdNearest, 16'd0, 16'd0, 10'h3FF}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd1, 16'd0, 32'd362, 1'b0}},
    // duplicate position, then a tie that the lower index must win
    '{'{nntt_pkg::CmdAdd, 16'd0, 16'd0, 10'd2}, 1'b0, '0},
    '{'{nntt_pkg::CmdNearest, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd1, 16'd0, 32'd362, 1'b0}},
    '{'{nntt_pkg::CmdNearest, 16'd0, 16'hFFFF, 10'd0}, 1'b0, '0},
    '{'{nntt_pkg::CmdNearest, 16'hFFFF, 16'd0, 10'd0}, 1'b0, '0},
    '{'{nntt_pkg::CmdAdd, 16'd256, 16'd256, 10'd6}, 1'b0, '0},
    '{'{nntt_pkg::CmdNearest, 16'd256, 16'd256, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd0, 16'd0, 32'd0, 1'b0}},
    '{'{nntt_pkg::CmdUnused, 16'd0, 16'hFFFF, 10'd0}, 1'b1, '0},
    '{'{nntt_pkg::CmdResetTree, 16'd0, 16'd0, 10'd0}, 1'b1, '0},
    '{'{nntt_pkg::CmdNearest, 16'hFFFF, 16'd0, 10'd0}, 1'b0, '0},
    // zero-length edge from the root
    '{'{nntt_pkg::CmdAdd, 16'd256, 16'd256, 10'd0}, 1'b1,
      '{nntt_pkg::StatusOk, 10'd1, 16'd0, 32'd0, 1'b0}}
  };

  // clock, reset and all unit inputs start at known values
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [nntt_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [nntt_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic [1:0] command_i = '0;
  logic [nntt_pkg::CoordW-1:0] point_x_i = '0;
  logic [nntt_pkg::CoordW-1:0] point_y_i = '0;
  logic [nntt_pkg::IdxW-1:0] parent_index_i = '0;
  logic out_ready_i = 1'b0;

  logic in_ready_o;
  logic out_valid_o;
  logic [1:0] status_o;
  logic [nntt_pkg::IdxW-1:0] node_index_o;
  logic [nntt_pkg::CoordW-1:0] distance_o;
  logic [nntt_pkg::CostW-1:0] cost_o;
  logic reached_o;

  // predicted tree and register copy
  logic [nntt_pkg::CoordW-1:0] tree_x [nntt_pkg::MaxNodes];
  logic [nntt_pkg::CoordW-1:0] tree_y [nntt_pkg::MaxNodes];
  logic [nntt_pkg::CostW-1:0] tree_cost [nntt_pkg::MaxNodes];
  int unsigned tree_size;
  logic [nntt_pkg::CoordW-1:0] root_x_reg, root_y_reg, goal_x_reg, goal_y_reg, reach_thr_reg;

  answer_t pending_answers [$];

  int mismatches = 0;
  int answers_checked = 0;
  int requests_sent = 0;
  int full_refusals = 0;
  int parent_refusals = 0;
  int goal_hits = 0;
  int unsigned peak_size = 1;
  int cycle_count = 0;
  bit steady_flow = 1'b0;    // no gaps on either side while set
  bit offering = 1'b0;       // request valid currently driven high
  bit long_hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  nearest_node_tree_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .parent_index_i (parent_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .node_index_o   (node_index_o),
    .distance_o     (distance_o),
    .cost_o         (cost_o),
    .reached_o      (reached_o)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               pending_answers.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // exact squared euclidean distance between two Q8.8 points
  function automatic logic [63:0] span_sq(logic [nntt_pkg::CoordW-1:0] ax, ay, bx, by);
    logic [63:0] dx, dy;
    dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
    dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
    return dx * dx + dy * dy;
  endfunction

  // integer square root rounded down, settled one bit at a time from the top
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r, trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  // tree back to the root alone, taken from the start registers as they are now
  function automatic void plant_root();
    tree_x[0] = root_x_reg;
    tree_y[0] = root_y_reg;
    tree_cost[0] = '0;
    tree_size = 1;
  endfunction

  // advances the predicted tree by one accepted request and gives its answer
  function automatic answer_t apply_request(request_t rq);
    answer_t ans;
    logic [63:0] d2, best_d2, goal_d2, sum;
    logic [31:0] root;
    int unsigned best;
    ans = '0;
    case (rq.cmd)
      nntt_pkg::CmdResetTree: plant_root();
      nntt_pkg::CmdNearest: begin
        best = 0;
        best_d2 = span_sq(rq.px, rq.py, tree_x[0], tree_y[0]);
        // strict compare keeps the lowest index on a tie
        for (int i = 1; i < tree_size; i++) begin
          d2 = span_sq(rq.px, rq.py, tree_x[i], tree_y[i]);
          if (d2 < best_d2) begin
            best_d2 = d2;
            best = i;
          end
        end
        root = floor_root(best_d2);
        ans.node = nntt_pkg::IdxW'(best);
        ans.distance = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
        ans.cost = tree_cost[best];
      end
      nntt_pkg::CmdAdd: begin
        // full table is checked ahead of the parent
        if (tree_size >= nntt_pkg::MaxNodes) begin
          ans.status = nntt_pkg::StatusFull;
          full_refusals++;
        end else if (rq.parent >= tree_size) begin
          ans.status = nntt_pkg::StatusBadParent;
          parent_refusals++;
        end else begin
          root = floor_root(span_sq(rq.px, rq.py, tree_x[rq.parent], tree_y[rq.parent]));
          // cost uses the unsaturated root, then saturates at 32 bits
          sum = 64'(tree_cost[rq.parent]) + 64'(root);
          if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
          goal_d2 = span_sq(rq.px, rq.py, goal_x_reg, goal_y_reg);
          tree_x[tree_size] = rq.px;
          tree_y[tree_size] = rq.py;
          tree_cost[tree_size] = sum[31:0];
          ans.node = nntt_pkg::IdxW'(tree_size);
          ans.distance = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
          ans.cost = sum[31:0];
          ans.reached = goal_d2 < 64'(reach_thr_reg) * 64'(reach_thr_reg);
          if (ans.reached) goal_hits++;
          tree_size++;
          if (tree_size > peak_size) peak_size = tree_size;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // random coordinate within spread of a centre, clipped to the Q8.8 range
  function automatic logic [nntt_pkg::CoordW-1:0] jitter(logic [nntt_pkg::CoordW-1:0] centre,
                                                         int unsigned spread);
    int v;
    v = int'(centre) + int'($urandom_range(2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return nntt_pkg::CoordW'(v);
  endfunction

  // mostly well-formed tree growth and queries, some refusals and noise
  function automatic request_t random_request();
    request_t rq;
    int unsigned pick, base;
    pick = $urandom_range(99);
    rq.cmd = nntt_pkg::CmdNearest;
    rq.px = nntt_pkg::CoordW'($urandom);
    rq.py = nntt_pkg::CoordW'($urandom);
    rq.parent = nntt_pkg::IdxW'($urandom);
    if (pick < 52) begin
      rq.cmd = nntt_pkg::CmdAdd;
      if (tree_size < nntt_pkg::MaxNodes) begin
        rq.parent = nntt_pkg::IdxW'($urandom_range(tree_size - 1));
        case ($urandom_range(2))
          0: begin
            rq.px = jitter(tree_x[rq.parent], 512);
            rq.py = jitter(tree_y[rq.parent], 512);
          end
          1: begin
            rq.px = jitter(goal_x_reg, int'(reach_thr_reg) + 32);
            rq.py = jitter(goal_y_reg, int'(reach_thr_reg) + 32);
          end
          default: ;
        endcase
      end
    end else if (pick < 80) begin
      // half the queries land on or close to a stored node
      if ($urandom_range(1)) begin
        base = $urandom_range(tree_size - 1);
        rq.px = jitter(tree_x[base], $urandom_range(1) ? 0 : 256);
        rq.py = jitter(tree_y[base], $urandom_range(1) ? 0 : 256);
      end
    end else if (pick < 88) begin
      rq.cmd = nntt_pkg::CmdAdd;
      if (tree_size < nntt_pkg::MaxNodes) begin
        rq.parent = nntt_pkg::IdxW'($urandom_range(nntt_pkg::MaxNodes - 1, tree_size));
      end
    end else if (pick < 94) begin
      rq.cmd = nntt_pkg::CmdResetTree;
    end else begin
      rq.cmd = nntt_pkg::CmdUnused;
    end
    return rq;
  endfunction

  // offers one request after a random gap and records its answer on acceptance
  task automatic offer_request(request_t rq, bit by_hand, answer_t typed);
    int unsigned gap;
    answer_t predicted;
    gap = steady_flow ? 0 : $urandom_range(9);
    if (gap > 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= rq.cmd;
    point_x_i <= rq.px;
    point_y_i <= rq.py;
    parent_index_i <= rq.parent;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_request(rq);
    pending_answers.insert(pending_answers.size(), by_hand ? typed : predicted);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // stops offering and waits until every answer is back, so the unit is idle
  task automatic settle_idle();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // register write, one per cycle; the caller drops the enable afterwards
  task automatic write_reg(logic [nntt_pkg::CfgIdxW-1:0] idx,
                           logic [nntt_pkg::CoordW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    case (idx)
      nntt_pkg::RegStartX:    root_x_reg = val;
      nntt_pkg::RegStartY:    root_y_reg = val;
      nntt_pkg::RegGoalX:     goal_x_reg = val;
      nntt_pkg::RegGoalY:     goal_y_reg = val;
      nntt_pkg::RegThreshold: reach_thr_reg = val;
      default: ;    // spare indices are ignored by the unit
    endcase
  endtask

  // answer sink: random hold-offs, one long stall, field by field compare
  initial begin : answer_sink
    int unsigned hold;
    answer_t want;
    bit taking;
    taking = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(9);
      if (!long_hold_done && answers_checked == 40) begin
        hold = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        if (taking) out_ready_i <= 1'b0;
        taking = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      taking = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_answers.size() == 0) begin
        $error("answer with no request outstanding: status %0d node %0d", status_o,
               node_index_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (node_index_o !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, node_index_o);
          mismatches++;
        end
        if (distance_o !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance_o);
          mismatches++;
        end
        if (cost_o !== want.cost) begin
          $error("cost: expected %0d, got %0d", want.cost, cost_o);
          mismatches++;
        end
        if (reached_o !== want.reached) begin
          $error("reached: expected %0d, got %0d", want.reached, reached_o);
          mismatches++;
        end
        answers_checked++;
      end
      @(negedge clk_i);
    end
  end

  // request source and run control
  initial begin : request_source
    request_t rq;
    root_x_reg = nntt_pkg::StartXRst;
    root_y_reg = nntt_pkg::StartYRst;
    goal_x_reg = nntt_pkg::GoalXRst;
    goal_y_reg = nntt_pkg::GoalYRst;
    reach_thr_reg = nntt_pkg::ThresholdRst;
    plant_root();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows against the reset registers
    foreach (DirectedRows[r]) offer_request(DirectedRows[r].rq, DirectedRows[r].by_hand,
                                            DirectedRows[r].want);

    // random part, one register setting per phase
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle_idle();
      case (phase)
        0: begin
          // spare indices only: nothing may change
          for (int r = nntt_pkg::RegThreshold + 1; r < 2 ** nntt_pkg::CfgIdxW; r++)
            write_reg(nntt_pkg::CfgIdxW'(r), nntt_pkg::CoordW'($urandom));
        end
        1: begin
          write_reg(nntt_pkg::RegStartX, '0);
          write_reg(nntt_pkg::RegStartY, '0);
          write_reg(nntt_pkg::RegGoalX, '1);
          write_reg(nntt_pkg::RegGoalY, '1);
          write_reg(nntt_pkg::RegThreshold, '1);
        end
        2: begin
          // zero threshold: nothing can ever reach the goal
          write_reg(nntt_pkg::RegStartX, '1);
          write_reg(nntt_pkg::RegStartY, '1);
          write_reg(nntt_pkg::RegGoalX, '0);
          write_reg(nntt_pkg::RegGoalY, '0);
          write_reg(nntt_pkg::RegThreshold, '0);
        end
        4: begin
          write_reg(nntt_pkg::RegStartX, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegStartY, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegGoalX, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegGoalY, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegThreshold, nntt_pkg::CoordW'(1));
        end
        6: begin
          write_reg(nntt_pkg::RegStartX, nntt_pkg::StartXRst);
          write_reg(nntt_pkg::RegStartY, nntt_pkg::StartYRst);
          write_reg(nntt_pkg::RegGoalX, nntt_pkg::GoalXRst);
          write_reg(nntt_pkg::RegGoalY, nntt_pkg::GoalYRst);
          write_reg(nntt_pkg::RegThreshold, nntt_pkg::ThresholdRst);
        end
        default: begin
          write_reg(nntt_pkg::RegStartX, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegStartY, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegGoalX, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegGoalY, nntt_pkg::CoordW'($urandom));
          write_reg(nntt_pkg::RegThreshold,
                    $urandom_range(1) ? nntt_pkg::CoordW'($urandom) :
                                        nntt_pkg::CoordW'($urandom_range(4096)));
        end
      endcase
      cfg_we_i <= 1'b0;
      steady_flow = (phase == 3 || phase == 6);
      // odd phases keep the old root until a random tree clear comes along
      if (phase % 2 == 0) begin
        rq = '{nntt_pkg::CmdResetTree, '0, '0, '0};
        offer_request(rq, 1'b0, '0);
      end
      repeat (PhaseRequests) offer_request(random_request(), 1'b0, '0);
    end
    steady_flow = 1'b0;

    // a few last adds and queries on whatever tree the random part left
    repeat (4) begin
      rq = random_request();
      rq.cmd = nntt_pkg::CmdAdd;
      offer_request(rq, 1'b0, '0);
    end
    rq.cmd = nntt_pkg::CmdNearest;
    offer_request(rq, 1'b0, '0);
    rq.cmd = nntt_pkg::CmdResetTree;
    offer_request(rq, 1'b0, '0);
    rq.cmd = nntt_pkg::CmdNearest;
    offer_request(rq, 1'b0, '0);

    settle_idle();
    repeat (TailCycles) @(negedge clk_i);

    $display("%0d requests over %0d register settings, largest tree %0d nodes, %0d answers",
             requests_sent, PhaseCount + 1, peak_size, answers_checked);
    $display("refused: %0d full, %0d bad parent; %0d adds landed within the goal radius",
             full_refusals, parent_refusals, goal_hits);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
